// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder package
// Item types, character codes and helper functions for the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_end;
	} enc_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_terminator;
		logic       decode_ok;
	} dec_item_t;

	// one accepted item worth of results: up to three bytes, then maybe the terminator
	typedef struct packed {
		logic [1:0]      nbytes;
		logic [2:0][7:0] bytes;
		logic            term;
		logic            ok;
	} upd_bundle_t;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef enum logic [2:0] {
		PEND_IDLE  = 3'b001,
		PEND_PCT   = 3'b010,
		PEND_DIGIT = 3'b100
	} pend_state_t;

	// returns {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		logic [4:0] r;
		v = 8'd0;
		r = 5'd0;
		if (c >= CH_0 && c <= CH_9) begin
			v = c - CH_0;
			r = {1'b1, v[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = c - CH_LA + HEX_TEN;
			r = {1'b1, v[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			v = c - CH_UA + HEX_TEN;
			r = {1'b1, v[3:0]};
		end
		return r;
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

// ===== rtl/core/upd_front.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts encoded items, tracks escape state and capacity, builds result bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               enc_valid,
	output logic               enc_ready,
	input  upd_pkg::enc_item_t enc_item,
	input  logic               q_full,
	output logic               push,
	output upd_pkg::upd_bundle_t bundle
);
	import upd_pkg::*;

	logic [15:0] capacity_q;
	pend_state_t pend_q;
	logic [7:0]  first_q;
	logic [15:0] emitted_q;

	logic        accept;
	pend_state_t pend_d;
	logic [7:0]  first_d;
	logic [1:0]  want;
	logic [1:0]  granted;
	logic [15:0] limit;
	logic [15:0] room;
	logic [4:0]  hx_hi;
	logic [4:0]  hx_lo;
	logic [7:0]  b;

	assign enc_ready = !q_full;
	assign accept    = enc_valid && enc_ready;
	assign b         = enc_item.in_byte;
	assign hx_hi     = hex_val(first_q);
	assign hx_lo     = hex_val(b);
	assign limit     = (capacity_q == 16'd0) ? 16'd0 : capacity_q - 16'd1;
	assign room      = (emitted_q >= limit) ? 16'd0 : limit - emitted_q;
	assign granted   = (room >= {14'd0, want}) ? want : room[1:0];

	always_comb begin
		pend_d       = pend_q;
		first_d      = first_q;
		want         = 2'd0;
		bundle.bytes = '0;
		bundle.term  = enc_item.is_end;
		bundle.ok    = enc_item.is_end && (capacity_q != 16'd0);
		if (enc_item.is_end) begin
			pend_d  = PEND_IDLE;
			first_d = 8'd0;
			if (pend_q == PEND_PCT) begin
				want            = 2'd1;
				bundle.bytes[0] = CH_PCT;
			end else if (pend_q == PEND_DIGIT) begin
				want            = 2'd2;
				bundle.bytes[0] = CH_PCT;
				bundle.bytes[1] = plain_byte(first_q);
			end
		end else begin
			unique case (pend_q)
				PEND_PCT: begin
					first_d = b;
					pend_d  = PEND_DIGIT;
				end
				PEND_DIGIT: begin
					pend_d  = PEND_IDLE;
					first_d = 8'd0;
					if (hx_hi[4] && hx_lo[4]) begin
						want            = 2'd1;
						bundle.bytes[0] = {hx_hi[3:0], hx_lo[3:0]};
					end else if (first_q == CH_PCT) begin
						want            = 2'd1;
						bundle.bytes[0] = CH_PCT;
						pend_d          = PEND_DIGIT;
						first_d         = b;
					end else if (b == CH_PCT) begin
						want            = 2'd2;
						bundle.bytes[0] = CH_PCT;
						bundle.bytes[1] = plain_byte(first_q);
						pend_d          = PEND_PCT;
					end else begin
						want            = 2'd3;
						bundle.bytes[0] = CH_PCT;
						bundle.bytes[1] = plain_byte(first_q);
						bundle.bytes[2] = plain_byte(b);
					end
				end
				default: begin
					pend_d = PEND_IDLE;
					if (b == CH_PCT) begin
						pend_d = PEND_PCT;
					end else begin
						want            = 2'd1;
						bundle.bytes[0] = plain_byte(b);
					end
				end
			endcase
		end
		bundle.nbytes = granted;
	end

	assign push = accept && (enc_item.is_end || (granted != 2'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
			pend_q     <= PEND_IDLE;
			first_q    <= 8'd0;
			emitted_q  <= 16'd0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				pend_q  <= pend_d;
				first_q <= first_d;
				if (enc_item.is_end) begin
					emitted_q <= 16'd0;
				end else begin
					emitted_q <= emitted_q + {14'd0, granted};
				end
			end
		end
	end

endmodule

// ===== rtl/core/upd_fifo.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder bundle queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  upd_pkg::upd_bundle_t wr_data,
	input  logic                 pop,
	output upd_pkg::upd_bundle_t rd_data,
	output logic                 full,
	output logic                 empty
);
	import upd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upd_bundle_t    mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/upd_back.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Unpacks queued bundles into single result items through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  upd_pkg::upd_bundle_t head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 dec_valid,
	input  logic                 dec_ready,
	output upd_pkg::dec_item_t   dec_item
);
	import upd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	dec_item_t  item_q;
	dec_item_t  next_item;
	logic [2:0] total;
	logic       load;
	logic       last;

	assign total = {1'b0, head.nbytes} + {2'b00, head.term};
	assign load  = head_valid && (!valid_q || dec_ready);
	assign last  = ({1'b0, idx_q} + 3'd1) == total;
	assign pop   = load && last;

	always_comb begin
		next_item = '0;
		if (idx_q < head.nbytes) begin
			case (idx_q)
				2'd0:    next_item.out_byte = head.bytes[0];
				2'd1:    next_item.out_byte = head.bytes[1];
				default: next_item.out_byte = head.bytes[2];
			endcase
		end else begin
			next_item.is_terminator = 1'b1;
			next_item.decode_ok     = head.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= next_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (dec_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign dec_valid = valid_q;
	assign dec_item  = item_q;

endmodule

// ===== rtl/core/url_percent_decoder_top.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming form-urlencoded decoder: one encoded byte in, decoded bytes out.
// ----------------------------------------------------------------------------
// Input channel enc_valid / enc_ready / enc_item carries one byte per item,
// or an end mark (is_end). Output channel dec_valid / dec_ready / dec_item
// carries one decoded byte per item; each string closes with a terminator
// item (zero byte, decode_ok clear when the capacity is zero).
// cfg_we / cfg_wdata write the output capacity (reset 65535) between strings.
// The front end queues a bundle for each accepted item that releases results;
// the back end loads them from the queue head into the output register.
// Throughput: one input item per cycle while the queue has room; output runs
// at one item per cycle while dec_ready is high; the FIFO_DEPTH-entry queue
// absorbs the three bytes that one input item can release.
// If the receiver stalls, the queue fills and enc_ready drops; nothing is lost.
// Reset clears the escape state, the byte count and the queue, and sets the
// capacity to 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module url_percent_decoder_top #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               enc_valid,
	output logic               enc_ready,
	input  upd_pkg::enc_item_t enc_item,
	output logic               dec_valid,
	input  logic               dec_ready,
	output upd_pkg::dec_item_t dec_item
);
	import upd_pkg::*;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	upd_bundle_t q_wr;
	upd_bundle_t q_rd;
	logic        dec_term;
	logic        dec_byte;

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.enc_valid (enc_valid),
		.enc_ready (enc_ready),
		.enc_item  (enc_item),
		.q_full    (q_full),
		.push      (q_push),
		.bundle    (q_wr)
	);

	upd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rd),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec_item   (dec_item)
	);

	assign dec_term = dec_valid && dec_item.is_terminator;
	assign dec_byte = dec_valid && !dec_item.is_terminator;

	`ASSERT_IMPLY(a_no_push_full, q_push, !q_full, "bundle pushed into full queue")
	`ASSERT_IMPLY(a_term_zero, dec_term, dec_item.out_byte == 8'd0, "terminator byte set")
	`ASSERT_IMPLY(a_byte_not_ok, dec_byte, !dec_item.decode_ok, "byte item flagged ok")
	`ASSERT_CLK(a_queued_nonempty, q_empty || q_rd.term || (q_rd.nbytes != 2'd0), "empty bundle")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Drives encoded strings, some fixed and most random, into the decoder with
// random idle cycles on both sides. Capacity is changed between items
// while no output is outstanding. Most decoded items are checked against
// an internal percent-decoding model with its own escape state and byte count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import upd_pkg::*;

	typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		enc_item_t  it;
		logic [15:0] cap;
		logic       typed;
		dec_item_t  want;
	} row_t;

	localparam int N_ROWS = 29;
	localparam row_t SCRIPT [N_ROWS] = '{
		'{ROW_ITEM, '{8'h61, 1'b0}, 16'd0, 1'b1, '{8'h61, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'h2B, 1'b0}, 16'd0, 1'b1, '{8'h20, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'h00, 1'b0}, 16'd0, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'hFF, 1'b0}, 16'd0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h34, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h31, 1'b0}, 16'd0, 1'b1, '{8'h41, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h66, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h46, 1'b0}, 16'd0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h47, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h2B, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h2B, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h7A, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'hFF, 1'b1}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h00, 1'b1}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h5A, 1'b1}, 16'd0, 1'b1, '{8'h00, 1'b1, 1'b1}},
		'{ROW_CAP,  '{8'h00, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h78, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h00, 1'b1}, 16'd0, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{ROW_CAP,  '{8'h00, 1'b0}, 16'd2, 1'b0, '0},
		'{ROW_ITEM, '{8'h70, 1'b0}, 16'd0, 1'b1, '{8'h70, 1'b0, 1'b0}},
		'{ROW_ITEM, '{8'h71, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h25, 1'b0}, 16'd0, 1'b0, '0},
		'{ROW_ITEM, '{8'h00, 1'b1}, 16'd0, 1'b1, '{8'h00, 1'b1, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        enc_valid;
	logic        enc_ready;
	enc_item_t   enc_item;
	logic        dec_valid;
	logic        dec_ready;
	dec_item_t   dec_item;

	// decoder model state
	logic [15:0] cap_now = 16'hFFFF;
	pend_state_t esc_state = PEND_IDLE;
	logic [7:0]  held_byte = 8'h00;
	logic [15:0] emitted = 16'd0;

	dec_item_t   decoded_q [$];
	int          mismatches = 0;
	int          items_sent = 0;
	bit          no_idle = 1'b0;

	url_percent_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.enc_valid (enc_valid),
		.enc_ready (enc_ready),
		.enc_item  (enc_item),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_item  (dec_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
		logic [7:0] d;
		d = 8'h00;
		nibble_of = 1'b1;
		if (c >= CH_0 && c <= CH_9)
			d = c - CH_0;
		else if (c >= CH_LA && c <= CH_LF)
			d = c - CH_LA + 8'd10;
		else if (c >= CH_UA && c <= CH_UF)
			d = c - CH_UA + 8'd10;
		else
			nibble_of = 1'b0;
		v = d[3:0];
	endfunction

	function automatic void release_byte(input logic [7:0] b);
		int unsigned room;
		room = (cap_now == 16'd0) ? 0 : int'(cap_now) - 1;
		if (int'(emitted) < room) begin
			decoded_q.push_back('{b, 1'b0, 1'b0});
			emitted = emitted + 16'd1;
		end
	endfunction

	function automatic void release_plain(input logic [7:0] b);
		release_byte((b == CH_PLUS) ? CH_SPACE : b);
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (b == CH_PCT)
			esc_state = PEND_PCT;
		else
			release_plain(b);
	endfunction

	function automatic void decode_step(input enc_item_t it);
		logic [3:0] hi, lo;
		logic [7:0] first;
		bit         ok_hi, ok_lo;
		if (it.is_end) begin
			if (esc_state == PEND_PCT) begin
				release_byte(CH_PCT);
			end else if (esc_state == PEND_DIGIT) begin
				release_byte(CH_PCT);
				release_plain(held_byte);
			end
			decoded_q.push_back('{8'h00, 1'b1, cap_now != 16'd0});
			esc_state = PEND_IDLE;
			held_byte = 8'h00;
			emitted = 16'd0;
		end else if (esc_state == PEND_PCT) begin
			held_byte = it.in_byte;
			esc_state = PEND_DIGIT;
		end else if (esc_state == PEND_DIGIT) begin
			first = held_byte;
			ok_hi = nibble_of(first, hi);
			ok_lo = nibble_of(it.in_byte, lo);
			esc_state = PEND_IDLE;
			held_byte = 8'h00;
			if (ok_hi && ok_lo) begin
				release_byte({hi, lo});
			end else begin
				release_byte(CH_PCT);
				take_plain(first);
				if (esc_state == PEND_PCT) begin
					held_byte = it.in_byte;
					esc_state = PEND_DIGIT;
				end else begin
					take_plain(it.in_byte);
				end
			end
		end else begin
			take_plain(it.in_byte);
		end
	endfunction

	function automatic void flag_mismatch(input string what, input dec_item_t w,
			input dec_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: want byte %h term %b ok %b, got byte %h term %b ok %b",
				$realtime, what, w.out_byte, w.is_terminator, w.decode_ok,
				got.out_byte, got.is_terminator, got.decode_ok);
	endfunction

	function automatic logic [7:0] hex_char();
		int unsigned v;
		v = $urandom_range(15);
		if (v < 10)
			return CH_0 + 8'(v);
		return (($urandom_range(1) != 0) ? CH_UA : CH_LA) + 8'(v - 10);
	endfunction

	always @(posedge clk) begin
		dec_item_t want;
		if (arst_n && dec_valid && dec_ready) begin
			if (decoded_q.size() == 0) begin
				flag_mismatch("unexpected item", '0, dec_item);
			end else begin
				want = decoded_q.pop_front();
				if (dec_item.out_byte !== want.out_byte ||
						dec_item.is_terminator !== want.is_terminator ||
						dec_item.decode_ok !== want.decode_ok)
					flag_mismatch("wrong item", want, dec_item);
			end
		end
		dec_ready <= no_idle || ($urandom_range(99) >= 38);
	end

	task automatic send_item(input enc_item_t it, input bit typed, input dec_item_t fixed);
		int unsigned base;
		enc_item <= it;
		enc_valid <= 1'b1;
		do @(posedge clk); while (!enc_ready);
		base = decoded_q.size();
		decode_step(it);
		if (typed) begin
			while (decoded_q.size() > base)
				void'(decoded_q.pop_back());
			decoded_q.push_back(fixed);
		end
		items_sent++;
		while (!no_idle && $urandom_range(99) < 38) begin
			enc_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item('{b, 1'b0}, 1'b0, '0);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		enc_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		// let items with no output leave the pipeline
		repeat (6) @(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cap_now = value;
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] cap_pick;
		int          phase;
		int          w;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 16'h0000;
		enc_valid <= 1'b0;
		enc_item <= '0;
		dec_ready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (SCRIPT[i].kind == ROW_CAP)
				write_capacity(SCRIPT[i].cap);
			else
				send_item(SCRIPT[i].it, SCRIPT[i].typed, SCRIPT[i].want);
		end

		items_sent = 0;
		phase = 0;
		while (items_sent < 350) begin
			no_idle = (phase == 4);
			case (phase)
				0: cap_pick = 16'hFFFF;
				1: cap_pick = 16'h0000;
				2: cap_pick = 16'h0001;
				default: begin
					case ($urandom_range(5))
						0: cap_pick = 16'h0000;
						1: cap_pick = 16'h0001;
						2: cap_pick = 16'h0002;
						3: cap_pick = 16'hFFFF;
						4: cap_pick = 16'($urandom_range(3, 12));
						default: cap_pick = 16'($urandom_range(65535));
					endcase
				end
			endcase
			write_capacity(cap_pick);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 10)) begin
					case ($urandom_range(9))
						0, 1, 2: send_byte(8'($urandom_range(8'h7E, 8'h20)));
						3: send_byte(8'($urandom_range(255)));
						4: send_byte(CH_PLUS);
						5, 6: begin
							send_byte(CH_PCT);
							send_byte(hex_char());
							send_byte(hex_char());
						end
						7: begin
							send_byte(CH_PCT);
							send_byte(8'($urandom_range(255)));
							send_byte(8'($urandom_range(255)));
						end
						8: begin
							send_byte(CH_PCT);
							send_byte(hex_char());
							send_byte(($urandom_range(1) != 0) ? CH_PCT : CH_PLUS);
						end
						default: begin
							send_byte(CH_PCT);
							send_byte(CH_PCT);
						end
					endcase
				end
				if ($urandom_range(9) != 0)
					send_item('{8'($urandom_range(255)), 1'b1}, 1'b0, '0);
			end
			phase++;
		end
		no_idle = 1'b0;

		enc_valid <= 1'b0;
		for (w = 0; w < 4000 && decoded_q.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (decoded_q.size() != 0)
			flag_mismatch("missing item", decoded_q.pop_front(), '0);

		if (mismatches == 0)
			$display("url_percent_decoder_top: match");
		else
			$display("url_percent_decoder_top: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("url_percent_decoder_top: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_fifo.sv
rtl/core/upd_back.sv
rtl/core/url_percent_decoder_top.sv
bench/tb.sv
